[hw/rtl/point_queue_with_sort_macros.svh]
`ifndef POINT_QUEUE_WITH_SORT_MACROS_SVH
`define POINT_QUEUE_WITH_SORT_MACROS_SVH

// same-cycle and next-cycle implication checks, clocked by clk, off in reset

`ifndef SYNTH
`define PQS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PQS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PQS_ASSERT_IMP(lbl, ante, cons, msg)
`define PQS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/pqs_pkg.sv]
package pqs_pkg;

    localparam int COORD_W       = 16;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 7;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_SORT = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } pqs_point_t;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
    } pqs_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
    } pqs_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pqs_sort_stat_t;

    // lexicographic order, x first then y, signed
    function automatic logic pqs_after(input pqs_point_t a, input pqs_point_t b);
        logic res;
        if (a.x != b.x)
        begin
            res = (a.x > b.x);
        end
        else
        begin
            res = (a.y > b.y);
        end
        return res;
    endfunction

endpackage

[hw/rtl/pqs_ram.sv]
module pqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/pqs_sorter.sv]
module pqs_sorter #(
    parameter int DEPTH = pqs_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [$clog2(DEPTH)-1:0]   head,
    input  logic [$clog2(DEPTH+1)-1:0] count,
    input  pqs_pkg::pqs_point_t        rd_data,
    output pqs_pkg::pqs_sort_stat_t    stat,
    output logic                       rd_en,
    output logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic                       wr_en,
    output logic [$clog2(DEPTH)-1:0]   wr_addr,
    output pqs_pkg::pqs_point_t        wr_data
);

    import pqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] last_reg, last_next;
    pqs_point_t    carry_reg, carry_next;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // one bubble pass per round: the larger point rides along in carry_reg,
    // the smaller one is written back one slot behind the read pointer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        carry_next = carry_reg;
        rd_en      = 1'b0;
        rd_addr    = head;
        wr_en      = 1'b0;
        wr_addr    = head;
        wr_data    = carry_reg;
        stat.busy  = (state_reg != S_IDLE);
        stat.done  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    last_next  = AW'(count - CW'(1));
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = head;
                idx_next   = AW'(1);
                state_next = S_FIRST;
            end
            S_FIRST:
            begin
                carry_next = rd_data;
                rd_en      = 1'b1;
                rd_addr    = slot_of(head, idx_reg);
                state_next = S_STEP;
            end
            S_STEP:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_of(head, idx_reg - AW'(1));
                if (pqs_after(carry_reg, rd_data))
                begin
                    wr_data = rd_data;
                end
                else
                begin
                    wr_data    = carry_reg;
                    carry_next = rd_data;
                end
                if (idx_reg != last_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = slot_of(head, idx_reg + AW'(1));
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_of(head, last_reg);
                wr_data = carry_reg;
                if (last_reg == AW'(1))
                begin
                    stat.done  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    last_next  = last_reg - AW'(1);
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

endmodule

[hw/rtl/point_queue_with_sort.sv]
// result is registered: it shows in the cycle after the last cycle of an item
// push, pop of the last point, failed pop, no-op, sort of at most one point: no point-memory read
// pop that leaves points behind: one point-memory read for the new head
// sort of n points: one bubble pass per memory sweep, then a point-memory read for the new head
// a result held by rsp_stall blocks the next transaction
// reset (async, active low) empties the queue; point memory is not cleared
`include "point_queue_with_sort_macros.svh"

module point_queue_with_sort #(
    parameter int DEPTH = pqs_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  pqs_pkg::pqs_in_t cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output pqs_pkg::pqs_out_t rsp
);

    import pqs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $bits(pqs_point_t);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    pqs_point_t    head_pt_reg, head_pt_next;
    pqs_point_t    pend_pt_reg, pend_pt_next;
    logic          pend_pop_reg, pend_pop_next;
    pqs_out_t      rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic           accept;
    logic           load_rsp;
    pqs_point_t     res_pt;
    logic [1:0]     res_status;
    pqs_point_t     in_pt;
    pqs_point_t     head_or_zero;
    logic           sort_start;
    pqs_sort_stat_t sort_stat;

    logic          ram_rd_en, ram_wr_en;
    logic [AW-1:0] ram_rd_addr, ram_wr_addr;
    pqs_point_t    ram_wr_data, ram_rd_data;
    logic [PW-1:0] ram_rd_bits;

    logic          srt_rd_en, srt_wr_en;
    logic [AW-1:0] srt_rd_addr, srt_wr_addr;
    pqs_point_t    srt_wr_data;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign cmd_stall    = !((state_reg == ST_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign accept       = cmd_valid && !cmd_stall;
    assign in_pt.x      = cmd.in_x;
    assign in_pt.y      = cmd.in_y;
    assign head_or_zero = (count_reg == '0) ? '0 : head_pt_reg;
    assign ram_rd_data  = ram_rd_bits;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        head_pt_next  = head_pt_reg;
        pend_pt_next  = pend_pt_reg;
        pend_pop_next = pend_pop_reg;
        load_rsp      = 1'b0;
        res_pt        = head_or_zero;
        res_status    = STATUS_OK;
        sort_start    = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = head_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = slot_of(head_reg, count_reg[AW-1:0]);
        ram_wr_data   = in_pt;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        OP_PUSH:
                        begin
                            load_rsp = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_status = STATUS_FULL;
                            end
                            else
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (count_reg == '0)
                                begin
                                    head_pt_next = in_pt;
                                    res_pt       = in_pt;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                load_rsp   = 1'b1;
                                res_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                head_next  = slot_of(head_reg, AW'(1));
                                if (count_reg == CW'(1))
                                begin
                                    load_rsp = 1'b1;
                                    res_pt   = head_pt_reg;
                                end
                                else
                                begin
                                    // fetch the new head, report the old one after
                                    ram_rd_en     = 1'b1;
                                    ram_rd_addr   = slot_of(head_reg, AW'(1));
                                    pend_pt_next  = head_pt_reg;
                                    pend_pop_next = 1'b1;
                                    state_next    = ST_LOAD;
                                end
                            end
                        end
                        OP_SORT:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                sort_start    = 1'b1;
                                pend_pop_next = 1'b0;
                                state_next    = ST_SORT;
                            end
                            else
                            begin
                                load_rsp = 1'b1;
                            end
                        end
                        default:
                        begin
                            load_rsp = 1'b1;
                        end
                    endcase
                end
            end
            ST_SORT:
            begin
                ram_rd_en   = srt_rd_en;
                ram_rd_addr = srt_rd_addr;
                ram_wr_en   = srt_wr_en;
                ram_wr_addr = srt_wr_addr;
                ram_wr_data = srt_wr_data;
                if (sort_stat.done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = head_reg;
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                head_pt_next = ram_rd_data;
                load_rsp     = 1'b1;
                res_pt       = pend_pop_reg ? pend_pt_reg : ram_rd_data;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next.out_x    = res_pt.x;
        rsp_next.out_y    = res_pt.y;
        rsp_next.status   = res_status;
        rsp_next.count    = COUNT_W'(count_next);
        rsp_next.is_empty = (count_next == '0);
        rsp_valid_next    = load_rsp || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pend_pop_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pend_pop_reg  <= pend_pop_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_pt_reg <= head_pt_next;
        pend_pt_reg <= pend_pt_next;
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    pqs_sorter #(
        .DEPTH(DEPTH)
    ) u_sorter (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sort_start),
        .head    (head_reg),
        .count   (count_reg),
        .rd_data (ram_rd_data),
        .stat    (sort_stat),
        .rd_en   (srt_rd_en),
        .rd_addr (srt_rd_addr),
        .wr_en   (srt_wr_en),
        .wr_addr (srt_wr_addr),
        .wr_data (srt_wr_data)
    );

    pqs_ram #(
        .WIDTH(PW),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_bits)
    );

    `PQS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "count above depth")
    `PQS_ASSERT_IMP(a_sort_owned, sort_stat.busy, state_reg == ST_SORT,
                    "sorter runs outside sort")
    `PQS_ASSERT_NXT(a_pop_fetch,
                    accept && (cmd.operation == OP_POP) && (count_reg > CW'(1)),
                    state_reg == ST_LOAD && !rsp_valid_reg, "pop did not fetch new head")
    `PQS_ASSERT_NXT(a_rsp_hold, rsp_valid_reg && rsp_stall,
                    rsp_valid_reg && $stable(rsp_reg), "pending result overwritten")

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pqs_pkg::*;

    localparam int QDEPTH      = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 16;
    localparam int RANDOM_OPS  = 1550;
    localparam int MAX_REPORTS = 10;

    // the block treats code three as a no-op that reports the head
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    pqs_in_t  cmd       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    pqs_out_t rsp;

    point_queue_with_sort #(
        .DEPTH(QDEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // queue state as the block should hold it
    logic signed [COORD_W-1:0] pt_x [QDEPTH];
    logic signed [COORD_W-1:0] pt_y [QDEPTH];
    int q_head  = 0;
    int q_count = 0;

    pqs_out_t awaited_reports [$];

    int fail_count   = 0;
    int cycle_count  = 0;
    int cmds_sent    = 0;
    int reports_seen = 0;
    int push_count   = 0;
    int pop_count    = 0;
    int sort_count   = 0;
    int full_drops   = 0;
    int empty_pops   = 0;
    int peak_count   = 0;
    int burst_left   = 0;

    function automatic pqs_out_t predict_queue_op(input pqs_in_t c);
        pqs_out_t r;
        logic signed [COORD_W-1:0] kx, ky;
        logic signed [COORD_W-1:0] sx [QDEPTH];
        logic signed [COORD_W-1:0] sy [QDEPTH];
        bit popped;
        int i, j;
        r        = '0;
        r.status = STATUS_OK;
        popped   = 1'b0;
        case (c.operation)
            OP_PUSH:
            begin
                push_count++;
                if (q_count >= QDEPTH)
                begin
                    r.status = STATUS_FULL;
                    full_drops++;
                end
                else
                begin
                    pt_x[(q_head + q_count) % QDEPTH] = c.in_x;
                    pt_y[(q_head + q_count) % QDEPTH] = c.in_y;
                    q_count++;
                end
            end
            OP_POP:
            begin
                pop_count++;
                if (q_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    r.out_x = pt_x[q_head];
                    r.out_y = pt_y[q_head];
                    q_head  = (q_head + 1) % QDEPTH;
                    q_count--;
                    popped  = 1'b1;
                end
            end
            OP_SORT:
            begin
                if (q_count > 1)
                begin
                    sort_count++;
                    // insertion sort in queue order, x first then y, signed
                    for (i = 0; i < q_count; i++)
                    begin
                        kx = pt_x[(q_head + i) % QDEPTH];
                        ky = pt_y[(q_head + i) % QDEPTH];
                        j  = i;
                        while (j > 0 && (sx[j-1] > kx || (sx[j-1] == kx && sy[j-1] > ky)))
                        begin
                            sx[j] = sx[j-1];
                            sy[j] = sy[j-1];
                            j--;
                        end
                        sx[j] = kx;
                        sy[j] = ky;
                    end
                    for (i = 0; i < q_count; i++)
                    begin
                        pt_x[(q_head + i) % QDEPTH] = sx[i];
                        pt_y[(q_head + i) % QDEPTH] = sy[i];
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (!popped && q_count != 0)
        begin
            r.out_x = pt_x[q_head];
            r.out_y = pt_y[q_head];
        end
        r.count    = q_count[COUNT_W-1:0];
        r.is_empty = (q_count == 0);
        if (q_count > peak_count)
            peak_count = q_count;
        return r;
    endfunction

    function automatic void flag_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("error at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
            // narrow range so that equal x values and ties are common
            3, 4, 5: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    // sender works in bursts with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_cmd(input logic [OP_W-1:0] op,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
        pqs_in_t c;
        c.operation = op;
        c.in_x      = x;
        c.in_y      = y;
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        awaited_reports.push_back(predict_queue_op(c));
        cmds_sent++;
        pace_sender();
    endtask

    // hold off the sender until every outstanding transaction has reported
    task automatic drain_pending();
        cmd_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_queue();
        send_cmd(OP_POP, 16'sh1234, 16'sh4321);
        send_cmd(OP_SORT, '0, '0);
        send_cmd(OP_UNUSED, 16'sh7FFF, 16'sh8000);
        send_cmd(OP_PUSH, 16'sd17, -16'sd3);
        send_cmd(OP_SORT, '0, '0);
        send_cmd(OP_POP, '0, '0);
        send_cmd(OP_POP, '0, '0);
        drain_pending();
    endtask

    task automatic test_extreme_points();
        send_cmd(OP_PUSH, 16'sh8000, 16'sh7FFF);
        send_cmd(OP_PUSH, 16'sh7FFF, 16'sh8000);
        send_cmd(OP_PUSH, 16'sh0000, 16'sh0000);
        send_cmd(OP_PUSH, 16'shFFFF, 16'shFFFF);
        send_cmd(OP_PUSH, 16'sd5, 16'sd7);
        send_cmd(OP_PUSH, 16'sd5, -16'sd7);
        send_cmd(OP_PUSH, 16'sh8000, 16'sh8000);
        send_cmd(OP_PUSH, 16'sh7FFF, 16'sh7FFF);
        send_cmd(OP_UNUSED, '0, '0);
        send_cmd(OP_SORT, '0, '0);
        repeat (3) send_cmd(OP_POP, '0, '0);
        send_cmd(OP_SORT, '0, '0);
        repeat (5) send_cmd(OP_POP, '0, '0);
        drain_pending();
    endtask

    task automatic test_fill_and_drain();
        while (q_count < QDEPTH)
            send_cmd(OP_PUSH, pick_coord(), pick_coord());
        repeat (3) send_cmd(OP_PUSH, pick_coord(), pick_coord());
        // pop then push at full moves the ring around
        send_cmd(OP_POP, '0, '0);
        send_cmd(OP_PUSH, pick_coord(), pick_coord());
        send_cmd(OP_SORT, '0, '0);
        send_cmd(OP_UNUSED, pick_coord(), pick_coord());
        while (q_count > 0)
            send_cmd(OP_POP, pick_coord(), pick_coord());
        repeat (2) send_cmd(OP_POP, pick_coord(), pick_coord());
        drain_pending();
    endtask

    task automatic test_random_traffic(input int n);
        int pw, r, k;
        pw = 50;
        for (k = 0; k < n; k++)
        begin
            // push bias changes every segment so the depth wanders end to end
            if (k % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pw = 25;
                    1: pw = 50;
                    2: pw = 75;
                    default: pw = 95;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                send_cmd(OP_SORT, pick_coord(), pick_coord());
            else if (r < 5)
                send_cmd(OP_UNUSED, pick_coord(), pick_coord());
            else if (r < 5 + (pw * 95) / 100)
                send_cmd(OP_PUSH, pick_coord(), pick_coord());
            else
                send_cmd(OP_POP, pick_coord(), pick_coord());
            if (k == n / 2)
                drain_pending();
        end
        drain_pending();
    endtask

    // receiver stall pattern: free, light random, or heavy stalling stretches
    int stall_mode = 0;
    int mode_left  = 0;
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 200);
        end
        else
        begin
            mode_left--;
        end
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 35);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    pqs_out_t want;
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            reports_seen++;
            if (awaited_reports.size() == 0)
            begin
                flag_failure($sformatf("unexpected transaction x=%0d y=%0d status=%0d count=%0d",
                                       rsp.out_x, rsp.out_y, rsp.status, rsp.count));
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (rsp.out_x !== want.out_x || rsp.out_y !== want.out_y ||
                    rsp.status !== want.status || rsp.count !== want.count ||
                    rsp.is_empty !== want.is_empty)
                begin
                    flag_failure($sformatf(
                        "got x=%0d y=%0d status=%0d count=%0d empty=%0b, want x=%0d y=%0d status=%0d count=%0d empty=%0b",
                        rsp.out_x, rsp.out_y, rsp.status, rsp.count, rsp.is_empty,
                        want.out_x, want.out_y, want.status, want.count, want.is_empty));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d transactions outstanding",
                     cycle_count, awaited_reports.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_extreme_points();
        test_fill_and_drain();
        test_random_traffic(RANDOM_OPS);
        test_fill_and_drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_reports.size() != 0)
            flag_failure($sformatf("%0d transactions never reported", awaited_reports.size()));

        $display("ran %0d commands, %0d reports checked, %0d mismatches", cmds_sent,
                 reports_seen, fail_count);
        $display("pushes %0d (dropped full %0d), pops %0d (empty %0d), sorts %0d, peak depth %0d",
                 push_count, full_drops, pop_count, empty_pops, sort_count, peak_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
